// ===== src/psr_pkg.sv =====
// ----------------------------------------------------------------------------
// Pitched sample resampler package
// Shared payload types, register indexes, operation codes and constants.
// ----------------------------------------------------------------------------
package psr_pkg;

  localparam int DEFAULT_DEPTH   = 65536;
  localparam int PITCH_W         = 14;
  localparam int RATE_W          = 19;
  localparam int FRAMES_W        = 17;
  localparam int CFG_W           = 19;
  localparam int DIV_STEPS       = 32;
  localparam int PITCH_FACTOR    = 375;
  localparam int MAX_DEVICE_RATE = 384000;
  localparam int PITCH_RESET     = 4096;
  localparam int RATE_RESET      = 48000;

  localparam logic [1:0] REG_PITCH  = 2'd0;
  localparam logic [1:0] REG_RATE   = 2'd1;
  localparam logic [1:0] REG_FRAMES = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [15:0]        address;
    logic signed [15:0] pcm_value;
    logic [31:0]        frame_num;
  } src_item_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [31:0] value;
  } res_item_t;

  typedef struct packed {
    logic                op;
    logic [15:0]         address;
    logic [15:0]         pcm_value;
    logic                ok;
    logic [FRAMES_W-1:0] frames;
  } meta_t;

endpackage

// ===== src/psr_ram.sv =====
// ----------------------------------------------------------------------------
// Pitched sample resampler RAM
// Generic memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module psr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== src/pitched_sample_resampler_top.sv =====
// ----------------------------------------------------------------------------
// Pitched sample resampler
// Linear interpolation sample rate converter over one stored PCM sample.
//
//   channel | valid     | stall     | payload
//   source  | src_valid | src_stall | src_data (src_item_t)
//   result  | res_valid | res_stall | res_data (res_item_t)
//   config  | cfg_write | none      | cfg_index, cfg_data
//
// One item is taken in every cycle while the result is not stalled; a read
// item's result passes two input stages, the divider load and its 32 steps,
// the sample store read, the product and the output register.
// Write items travel the same pipeline and update the store at the read stage.
// A stalled result freezes the whole pipeline; otherwise every stage advances.
// Reset clears the pipeline and the registers; the store has no reset.
// ----------------------------------------------------------------------------
module pitched_sample_resampler_top
  import psr_pkg::*;
#(
  parameter int SAMPLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_stall,
  input  src_item_t        src_data,
  output logic             res_valid,
  input  logic             res_stall,
  output res_item_t        res_data,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(SAMPLE_DEPTH);

  logic [PITCH_W-1:0]  pitch;
  logic [RATE_W-1:0]   out_rate;
  logic [FRAMES_W-1:0] sample_frames;
  logic [FRAMES_W-1:0] frames_eff;
  logic                cfg_ok;
  logic                en;

  logic                s1_v;
  meta_t               s1_meta;
  logic [31:0]         s1_n;
  logic [22:0]         s1_m;
  logic [35:0]         s1_lim;
  logic                s2_v;
  meta_t               s2_meta;
  meta_t               s2_chk;
  logic [54:0]         s2_p;
  logic [40:0]         s2_lim;

  logic                dv_v    [DIV_STEPS+1];
  meta_t               dv_meta [DIV_STEPS+1];
  logic [RATE_W-1:0]   dv_r    [DIV_STEPS+1];
  logic [31:0]         dv_q    [DIV_STEPS+1];
  logic [31:0]         dv_low  [DIV_STEPS+1];
  logic [RATE_W-1:0]   r_next  [DIV_STEPS];
  logic [31:0]         q_next  [DIV_STEPS];
  logic [31:0]         low_next[DIV_STEPS];

  logic [15:0]         idx;
  logic [16:0]         idx_inc;
  logic [15:0]         nxt;
  logic                ram_we;
  logic [15:0]         s0_raw;
  logic [15:0]         s1_raw;

  logic                rd_v;
  meta_t               rd_meta;
  logic [15:0]         rd_frac;
  logic signed [16:0]  diff;
  logic signed [33:0]  prod;

  logic                ex_v;
  meta_t               ex_meta;
  logic [15:0]         ex_s0;
  logic [33:0]         ex_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch         <= PITCH_W'(PITCH_RESET);
      out_rate      <= RATE_W'(RATE_RESET);
      sample_frames <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PITCH:  pitch         <= cfg_data[PITCH_W-1:0];
        REG_RATE:   out_rate      <= cfg_data;
        REG_FRAMES: sample_frames <= cfg_data[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  assign frames_eff = ({15'b0, sample_frames} > 32'(SAMPLE_DEPTH)) ?
                      FRAMES_W'(SAMPLE_DEPTH) : sample_frames;
  assign cfg_ok = (pitch != '0) && (out_rate != '0) &&
                  (out_rate <= RATE_W'(MAX_DEVICE_RATE)) && (frames_eff != '0);

  assign en        = !(res_valid && res_stall);
  assign src_stall = !en;

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      logic [RATE_W:0] t;
      logic [RATE_W:0] d;
      logic            ge;
      t  = {dv_r[k], dv_low[k][31]};
      d  = t - {1'b0, out_rate};
      ge = t >= {1'b0, out_rate};
      r_next[k]   = ge ? d[RATE_W-1:0] : t[RATE_W-1:0];
      q_next[k]   = {dv_q[k][30:0], ge};
      low_next[k] = {dv_low[k][30:0], 1'b0};
    end
  end

  always_comb begin
    s2_chk    = s2_meta;
    s2_chk.ok = s2_meta.ok && (s2_p < {14'b0, s2_lim});
  end

  assign idx     = dv_q[DIV_STEPS][31:16];
  assign idx_inc = {1'b0, idx} + 17'd1;
  assign nxt     = (idx_inc < dv_meta[DIV_STEPS].frames) ? idx_inc[15:0] : idx;
  assign ram_we  = en && dv_v[DIV_STEPS] && (dv_meta[DIV_STEPS].op == OP_WRITE) &&
                   ({16'b0, dv_meta[DIV_STEPS].address} < 32'(SAMPLE_DEPTH));

  psr_ram #(
    .WIDTH(16),
    .DEPTH(SAMPLE_DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (AW'(32'(dv_meta[DIV_STEPS].address))),
    .wdata  (dv_meta[DIV_STEPS].pcm_value),
    .re     (en),
    .raddr_a(AW'(32'(idx))),
    .raddr_b(AW'(32'(nxt))),
    .rdata_a(s0_raw),
    .rdata_b(s1_raw)
  );

  assign diff = $signed({s1_raw[15], s1_raw}) - $signed({s0_raw[15], s0_raw});
  assign prod = diff * $signed({1'b0, rd_frac});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      rd_v      <= 1'b0;
      ex_v      <= 1'b0;
      res_valid <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_v[k] <= 1'b0;
      end
    end else if (en) begin
      s1_v <= src_valid;
      s2_v <= s1_v;
      dv_v[0] <= s2_v;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        dv_v[k] <= dv_v[k-1];
      end
      rd_v      <= dv_v[DIV_STEPS];
      ex_v      <= rd_v;
      res_valid <= ex_v && (ex_meta.op == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_meta.op        <= src_data.op;
      s1_meta.address   <= src_data.address;
      s1_meta.pcm_value <= src_data.pcm_value;
      s1_meta.ok        <= cfg_ok;
      s1_meta.frames    <= frames_eff;
      s1_n              <= src_data.frame_num;
      s1_m              <= 23'(PITCH_FACTOR * int'(pitch));
      s1_lim            <= 36'(frames_eff) * 36'(out_rate);

      s2_meta <= s1_meta;
      s2_p    <= 55'(s1_n) * 55'(s1_m);
      s2_lim  <= {s1_lim, 5'b0};

      dv_meta[0]    <= s2_chk;
      dv_r[0]       <= s2_p[39:21];
      dv_q[0]       <= '0;
      dv_low[0]     <= {s2_p[20:0], 11'b0};
      for (int k = 1; k <= DIV_STEPS; k++) begin
        dv_meta[k] <= dv_meta[k-1];
        dv_r[k]    <= r_next[k-1];
        dv_q[k]    <= q_next[k-1];
        dv_low[k]  <= low_next[k-1];
      end

      rd_meta <= dv_meta[DIV_STEPS];
      rd_frac <= dv_q[DIV_STEPS][15:0];

      ex_meta <= rd_meta;
      ex_s0   <= s0_raw;
      ex_prod <= prod;

      res_data.valid_res <= ex_meta.ok;
      res_data.value     <= ex_meta.ok ? ({ex_s0, 16'h0} + ex_prod[31:0]) : '0;
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.valid_res |-> res_data.value == '0)
    else $error("invalid result carries a nonzero value");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dv_v[0] && dv_meta[0].ok && dv_meta[0].op == OP_READ |-> dv_r[0] < out_rate)
    else $error("initial divider remainder not below divisor");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    dv_v[DIV_STEPS] && dv_meta[DIV_STEPS].ok && dv_meta[DIV_STEPS].op == OP_READ
    |-> {1'b0, idx} < dv_meta[DIV_STEPS].frames)
    else $error("source index beyond the frame count");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    src_stall |=> $stable(rd_v) && $stable(ex_v))
    else $error("pipeline moved during a stall");
`endif

endmodule

// ===== test/psr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pitched sample resampler checker
// Watches the source, result and configuration ports of the resampler. It
// keeps its own copy of the registers and the sample store, predicts the
// interpolated output for every read transfer, and compares each result
// transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module psr_checker
  import psr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  input  logic             src_stall,
  input  src_item_t        src_data,
  input  logic             res_valid,
  input  logic             res_stall,
  input  res_item_t        res_data,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               result_count
);

  localparam longint unsigned NATIVE_RATE = 48000;
  localparam longint unsigned PITCH_UNITY = 4096;
  localparam longint unsigned STORE_DEPTH = DEFAULT_DEPTH;

  logic signed [15:0]  pcm_store [DEFAULT_DEPTH];
  logic [PITCH_W-1:0]  pitch_q;
  logic [RATE_W-1:0]   rate_q;
  logic [FRAMES_W-1:0] frames_q;
  res_item_t           sample_queue [$];

  function automatic res_item_t interpolate(logic [31:0] n);
    longint unsigned fe, num, den, last, ph, idx, nx, rem, frac;
    longint          s0, s1, v;
    res_item_t       r;
    r = '0;
    fe = (frames_q > STORE_DEPTH) ? STORE_DEPTH : longint'(frames_q);
    if (pitch_q == 0 || rate_q == 0 || rate_q > MAX_DEVICE_RATE || fe == 0) return r;
    num = NATIVE_RATE * pitch_q;
    den = PITCH_UNITY * rate_q;
    last = (fe * den + num - 1) / num;
    if (longint'(n) >= last) return r;
    ph = longint'(n) * num;
    idx = ph / den;
    rem = ph % den;
    nx = (idx + 1 < fe) ? idx + 1 : idx;
    frac = (rem * 65536) / den;
    s0 = longint'(pcm_store[idx]);
    s1 = longint'(pcm_store[nx]);
    v = s0 * 65536 + (s1 - s0) * longint'(frac);
    r.valid_res = 1'b1;
    r.value = v[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    res_item_t exp_r;
    if (rst) begin
      pitch_q <= PITCH_W'(PITCH_RESET);
      rate_q <= RATE_W'(RATE_RESET);
      frames_q <= '0;
      sample_queue.delete();
      fail_count <= 0;
      pending <= 0;
      result_count <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PITCH:  pitch_q <= cfg_data[PITCH_W-1:0];
          REG_RATE:   rate_q <= cfg_data[RATE_W-1:0];
          REG_FRAMES: frames_q <= cfg_data[FRAMES_W-1:0];
          default: ;
        endcase
      end
      if (src_valid && !src_stall) begin
        if (src_data.op == OP_WRITE) begin
          pcm_store[src_data.address] = src_data.pcm_value;
        end else begin
          sample_queue.push_back(interpolate(src_data.frame_num));
        end
      end
      if (res_valid && !res_stall) begin
        result_count <= result_count + 1;
        if (sample_queue.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result transfer: valid_res=%0b value=%0d",
                     res_data.valid_res, res_data.value);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = sample_queue.pop_front();
          if (exp_r.valid_res !== res_data.valid_res || exp_r.value !== res_data.value) begin
            if (fail_count < 10)
              $display("mismatch: expected valid_res=%0b value=%0d, got valid_res=%0b value=%0d",
                       exp_r.valid_res, exp_r.value, res_data.valid_res, res_data.value);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= sample_queue.size();
    end
  end

endmodule

// ===== test/pitched_sample_resampler_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pitched sample resampler testbench
// Loads the sample store, then runs directed and random read and write
// transfers over a range of pitch, output rate and frame count settings,
// with random idle cycles on both channels. A checker predicts every result.
// ----------------------------------------------------------------------------
module pitched_sample_resampler_top_test;
  import psr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN       = 60;
  localparam int PREFIX      = 64;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             src_valid = 1'b0;
  logic             src_stall;
  src_item_t        src_data = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  res_item_t        res_data;
  logic             cfg_write = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int               fail_count, pending, result_count;
  int               cycles = 0;
  int               sent = 0;
  int               settings = 0;
  bit               quiet = 1'b0;
  int               pitch_s = PITCH_RESET;
  int               rate_s = RATE_RESET;
  int               frames_s = 0;

  always #4 clk = ~clk;

  pitched_sample_resampler_top dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  psr_checker u_checker (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    int hold;
    if (res_valid && !res_stall) hold = quiet ? 0 : $urandom_range(0, 18);
    if (hold > 0) begin
      res_stall <= 1'b1;
      hold--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  task automatic send(src_item_t it);
    int gap;
    gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data <= it;
    do @(posedge clk); while (src_stall);
    sent++;
  endtask

  task automatic write_pcm(logic [15:0] addr, logic [15:0] pcm);
    src_item_t it;
    it = '0;
    it.op = OP_WRITE;
    it.address = addr;
    it.pcm_value = pcm;
    it.frame_num = $urandom;
    send(it);
  endtask

  task automatic read_frame(logic [31:0] n);
    src_item_t it;
    it.op = OP_READ;
    it.address = 16'($urandom);
    it.pcm_value = 16'($urandom);
    it.frame_num = n;
    send(it);
  endtask

  task automatic drain();
    if (src_valid) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, int val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PITCH:  pitch_s = val;
      REG_RATE:   rate_s = val;
      REG_FRAMES: frames_s = val;
      default: ;
    endcase
    settings++;
  endtask

  // Picks a frame; for valid setups with frames over the prefix, reads stay in it.
  function automatic logic [31:0] pick_frame();
    longint unsigned num, den, fe, last, cap;
    fe = (frames_s > DEFAULT_DEPTH) ? DEFAULT_DEPTH : frames_s;
    if (pitch_s == 0 || rate_s == 0 || rate_s > MAX_DEVICE_RATE || fe == 0 ||
        $urandom_range(0, 9) == 0) begin
      if (fe <= PREFIX || pitch_s == 0 || rate_s == 0 || rate_s > MAX_DEVICE_RATE)
        return $urandom;
    end
    num = 48000 * pitch_s;
    den = 4096 * rate_s;
    last = (fe * den + num - 1) / num;
    if (fe > PREFIX) begin
      cap = (PREFIX - 2) * den / num;
      return $urandom_range(0, int'(cap));
    end
    cap = last + 1;
    if (cap > 32'hFFFF_FFFF) cap = 32'hFFFF_FFFF;
    return $urandom_range(0, int'(cap));
  endfunction

  initial begin
    int p, r, f;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_pcm(16'd0, 16'h7FFF);
    write_pcm(16'd1, 16'h8000);
    write_pcm(16'd2, 16'h0000);
    write_pcm(16'd3, 16'hFFFF);
    write_pcm(16'hFFFF, 16'h5A5A);
    for (int i = 4; i < PREFIX; i++) write_pcm(16'(i), 16'($urandom));
    read_frame(0);
    set_reg(REG_FRAMES, 8);
    read_frame(0);
    read_frame(7);
    read_frame(8);
    read_frame(32'hFFFF_FFFF);
    set_reg(REG_FRAMES, 1);
    read_frame(0);
    read_frame(1);
    set_reg(REG_FRAMES, 131071);
    read_frame(5);
    read_frame(61);
    set_reg(REG_PITCH, 16383);
    read_frame(7);
    set_reg(REG_PITCH, 0);
    read_frame(0);
    set_reg(REG_PITCH, 1);
    set_reg(REG_RATE, 0);
    read_frame(0);
    set_reg(REG_RATE, 384001);
    read_frame(0);
    set_reg(REG_RATE, 524287);
    read_frame(0);
    set_reg(REG_RATE, 384000);
    read_frame(3);

    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph % 3 == 1);
      case ($urandom_range(0, 3))
        0: p = 1;
        1: p = 16383;
        2: p = PITCH_RESET;
        default: p = $urandom_range(0, 16383);
      endcase
      case ($urandom_range(0, 5))
        0: r = 1;
        1: r = MAX_DEVICE_RATE;
        2: r = RATE_RESET;
        3: r = 44100;
        4: r = $urandom_range(0, 524287);
        default: r = $urandom_range(1, MAX_DEVICE_RATE);
      endcase
      case ($urandom_range(0, 9))
        0: f = 0;
        1: f = 65536;
        2: f = 131071;
        default: f = $urandom_range(1, PREFIX);
      endcase
      set_reg(REG_PITCH, p);
      set_reg(REG_RATE, r);
      set_reg(REG_FRAMES, f);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 3) == 0)
          write_pcm(16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, PREFIX - 1) :
                        $urandom),
                    16'($urandom));
        else
          read_frame(pick_frame());
      end
    end

    drain();
    $display("Sent %0d transfers and checked %0d results over %0d register writes.",
             sent, result_count, settings);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
